@@ hdl/vms_pkg.sv @@
// Shared types and codes for the vehicle mode supervisor.
// Holds the mode, session, fault and command encodings and the item/state structs.
// No dependencies.
package vms_pkg;

  typedef enum logic [2:0] {
    MOT_BOOT    = 3'd0,
    MOT_IDLE    = 3'd1,
    MOT_REMOTE  = 3'd2,
    MOT_TUNING  = 3'd3,
    MOT_MANUAL  = 3'd4,
    MOT_ARMED   = 3'd5,
    MOT_RUNNING = 3'd6,
    MOT_FAULT   = 3'd7
  } motion_e;

  typedef enum logic [1:0] {
    SES_VIEW   = 2'd0,
    SES_REMOTE = 2'd1,
    SES_TUNING = 2'd2
  } session_e;

  typedef enum logic [2:0] {
    FLT_NONE    = 3'd0,
    FLT_SENSOR  = 3'd1,
    FLT_LINE    = 3'd2,
    FLT_SEND    = 3'd3,
    FLT_INVALID = 3'd4
  } fault_e;

  typedef enum logic [3:0] {
    CMD_REINIT       = 4'd0,
    CMD_FINISH_BOOT  = 4'd1,
    CMD_ENTER_REMOTE = 4'd2,
    CMD_EXIT_REMOTE  = 4'd3,
    CMD_ENTER_TUNING = 4'd4,
    CMD_EXIT_TUNING  = 4'd5,
    CMD_ARM_AUTO     = 4'd6,
    CMD_START_AUTO   = 4'd7,
    CMD_STOP         = 4'd8,
    CMD_CLEAR_FAULT  = 4'd9,
    CMD_ENTER_FAULT  = 4'd10,
    CMD_START_MANUAL = 4'd11,
    CMD_CHECK_EXPIRY = 4'd12,
    CMD_READ         = 4'd13
  } cmd_e;

  typedef struct packed {
    logic [3:0]         command;
    logic [31:0]        now_ms;
    logic [2:0]         fault_code;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [31:0] yaw;
    logic [31:0]        test_len_ms;
  } item_t;

  typedef struct packed {
    motion_e            motion;
    session_e           session;
    fault_e             fault;
    logic [31:0]        entered_ms;
    logic [31:0]        deadline;
    logic signed [15:0] hold_vx;
    logic signed [15:0] hold_vy;
    logic signed [31:0] hold_yaw;
  } state_t;

  typedef struct packed {
    logic   status;
    logic   expired;
    state_t snap;
    logic   bridge_live;
  } result_t;

  localparam state_t STATE_RESET = '{
    motion:     MOT_BOOT,
    session:    SES_VIEW,
    fault:      FLT_NONE,
    entered_ms: 32'd0,
    deadline:   32'd0,
    hold_vx:    16'sd0,
    hold_vy:    16'sd0,
    hold_yaw:   32'sd0
  };

endpackage

@@ hdl/vms_decide.sv @@
// Transition logic of the vehicle mode supervisor: one command against the current state.
// Produces the next state and the result item. Depends on vms_pkg.
module vms_decide (
  input  vms_pkg::item_t   item_i,
  input  vms_pkg::state_t  state_i,
  output vms_pkg::state_t  state_o,
  output vms_pkg::result_t result_o
);

  vms_pkg::state_t nxt;
  logic            status;
  logic            expired;
  logic [31:0]     since_deadline;
  logic            motion_zero;

  assign since_deadline = item_i.now_ms - state_i.deadline;
  assign motion_zero = (item_i.vx == 16'sd0) && (item_i.vy == 16'sd0) &&
                       (item_i.yaw == 32'sd0);

  always_comb begin
    nxt     = state_i;
    status  = 1'b0;
    expired = 1'b0;
    case (item_i.command)
      vms_pkg::CMD_REINIT: begin
        nxt            = vms_pkg::STATE_RESET;
        nxt.entered_ms = item_i.now_ms;
      end
      vms_pkg::CMD_FINISH_BOOT: begin
        if (state_i.motion == vms_pkg::MOT_BOOT) begin
          nxt.motion     = vms_pkg::MOT_IDLE;
          nxt.session    = vms_pkg::SES_VIEW;
          nxt.fault      = vms_pkg::FLT_NONE;
          nxt.entered_ms = item_i.now_ms;
        end
      end
      vms_pkg::CMD_ENTER_REMOTE: begin
        if ((state_i.motion inside {vms_pkg::MOT_IDLE, vms_pkg::MOT_REMOTE}) &&
            (state_i.session inside {vms_pkg::SES_VIEW, vms_pkg::SES_REMOTE})) begin
          nxt.motion     = vms_pkg::MOT_REMOTE;
          nxt.session    = vms_pkg::SES_REMOTE;
          nxt.fault      = vms_pkg::FLT_NONE;
          nxt.entered_ms = item_i.now_ms;
        end else begin
          status = 1'b1;
        end
      end
      vms_pkg::CMD_EXIT_REMOTE: begin
        if (state_i.motion == vms_pkg::MOT_IDLE && state_i.session == vms_pkg::SES_VIEW) begin
          // already out: hold everything
        end else if (state_i.motion == vms_pkg::MOT_REMOTE &&
                     state_i.session == vms_pkg::SES_REMOTE) begin
          nxt.motion     = vms_pkg::MOT_IDLE;
          nxt.session    = vms_pkg::SES_VIEW;
          nxt.fault      = vms_pkg::FLT_NONE;
          nxt.entered_ms = item_i.now_ms;
        end else begin
          status = 1'b1;
        end
      end
      vms_pkg::CMD_ENTER_TUNING: begin
        if (state_i.motion inside {vms_pkg::MOT_IDLE, vms_pkg::MOT_TUNING}) begin
          nxt            = vms_pkg::STATE_RESET;
          nxt.motion     = vms_pkg::MOT_TUNING;
          nxt.session    = vms_pkg::SES_TUNING;
          nxt.entered_ms = item_i.now_ms;
        end else begin
          status = 1'b1;
        end
      end
      vms_pkg::CMD_EXIT_TUNING: begin
        if (state_i.session == vms_pkg::SES_TUNING) begin
          nxt            = vms_pkg::STATE_RESET;
          nxt.motion     = vms_pkg::MOT_IDLE;
          nxt.entered_ms = item_i.now_ms;
        end else begin
          status = 1'b1;
        end
      end
      vms_pkg::CMD_ARM_AUTO: begin
        if (state_i.motion == vms_pkg::MOT_IDLE && state_i.session == vms_pkg::SES_VIEW) begin
          nxt.motion     = vms_pkg::MOT_ARMED;
          nxt.session    = vms_pkg::SES_VIEW;
          nxt.fault      = vms_pkg::FLT_NONE;
          nxt.entered_ms = item_i.now_ms;
        end else begin
          status = 1'b1;
        end
      end
      vms_pkg::CMD_START_AUTO: begin
        if (state_i.motion == vms_pkg::MOT_ARMED) begin
          nxt.motion     = vms_pkg::MOT_RUNNING;
          nxt.session    = vms_pkg::SES_VIEW;
          nxt.fault      = vms_pkg::FLT_NONE;
          nxt.entered_ms = item_i.now_ms;
        end else begin
          status = 1'b1;
        end
      end
      vms_pkg::CMD_STOP: begin
        nxt            = vms_pkg::STATE_RESET;
        nxt.motion     = vms_pkg::MOT_IDLE;
        nxt.entered_ms = item_i.now_ms;
      end
      vms_pkg::CMD_CLEAR_FAULT: begin
        if (state_i.motion == vms_pkg::MOT_FAULT) begin
          nxt            = vms_pkg::STATE_RESET;
          nxt.motion     = vms_pkg::MOT_IDLE;
          nxt.entered_ms = item_i.now_ms;
        end else begin
          status = 1'b1;
        end
      end
      vms_pkg::CMD_ENTER_FAULT: begin
        nxt            = vms_pkg::STATE_RESET;
        nxt.motion     = vms_pkg::MOT_FAULT;
        nxt.entered_ms = item_i.now_ms;
        // map none and unknown codes to the invalid reason
        if (item_i.fault_code inside {vms_pkg::FLT_SENSOR, vms_pkg::FLT_LINE,
                                      vms_pkg::FLT_SEND}) begin
          nxt.fault = vms_pkg::fault_e'(item_i.fault_code);
        end else begin
          nxt.fault = vms_pkg::FLT_INVALID;
        end
      end
      vms_pkg::CMD_START_MANUAL: begin
        if (state_i.motion == vms_pkg::MOT_TUNING && state_i.session == vms_pkg::SES_TUNING) begin
          nxt.hold_vx    = item_i.vx;
          nxt.hold_vy    = item_i.vy;
          nxt.hold_yaw   = item_i.yaw;
          nxt.session    = vms_pkg::SES_TUNING;
          nxt.fault      = vms_pkg::FLT_NONE;
          nxt.entered_ms = item_i.now_ms;
          if (motion_zero) begin
            nxt.deadline = 32'd0;
            nxt.motion   = vms_pkg::MOT_TUNING;
          end else begin
            nxt.deadline = item_i.now_ms + item_i.test_len_ms;
            nxt.motion   = vms_pkg::MOT_MANUAL;
          end
        end else begin
          status = 1'b1;
        end
      end
      vms_pkg::CMD_CHECK_EXPIRY: begin
        // signed wrap compare: expired once now has reached the deadline
        if (state_i.motion == vms_pkg::MOT_MANUAL && state_i.deadline != 32'd0 &&
            !since_deadline[31]) begin
          nxt            = vms_pkg::STATE_RESET;
          nxt.motion     = vms_pkg::MOT_TUNING;
          nxt.session    = vms_pkg::SES_TUNING;
          nxt.entered_ms = item_i.now_ms;
          expired        = 1'b1;
        end
      end
      default: begin
        // read and unused codes: hold state
      end
    endcase
  end

  assign state_o              = nxt;
  assign result_o.status      = status;
  assign result_o.expired     = expired;
  assign result_o.snap        = nxt;
  assign result_o.bridge_live = (nxt.motion == vms_pkg::MOT_REMOTE) &&
                                (nxt.session == vms_pkg::SES_REMOTE);

endmodule

@@ hdl/vehicle_mode_supervisor.sv @@
// Vehicle mode supervisor: takes one command item per cycle and returns one
// result item carrying a status and a snapshot of the mode state after the
// command. Each item passes the input register, then the result register; the
// throughput is one item per clock unless stalled, set by the combinational
// transition logic between the input register and the result register, which
// also writes the state registers. The input stalls only while a result is
// held by a stalled output and another item waits in the input register.
// Depends on vms_pkg and vms_decide.
module vehicle_mode_supervisor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         command_i,
  input  logic [31:0]        now_ms_i,
  input  logic [2:0]         fault_code_i,
  input  logic signed [15:0] cmd_vx_i,
  input  logic signed [15:0] cmd_vy_i,
  input  logic signed [31:0] cmd_yaw_i,
  input  logic [31:0]        test_len_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic               expired_o,
  output logic [2:0]         motion_mode_o,
  output logic [1:0]         session_mode_o,
  output logic [2:0]         fault_out_o,
  output logic [31:0]        entered_at_ms_o,
  output logic [31:0]        deadline_out_o,
  output logic signed [15:0] held_vx_o,
  output logic signed [15:0] held_vy_o,
  output logic signed [31:0] held_yaw_o,
  output logic               bridge_live_o
);

  vms_pkg::item_t   item_q;
  logic             item_valid_q;
  vms_pkg::state_t  state_q;
  vms_pkg::state_t  state_d;
  vms_pkg::result_t res_q;
  vms_pkg::result_t res_d;
  logic             res_valid_q;
  logic             fire;
  logic             in_accept;

  // advance the held item when the result register is free or draining
  assign fire       = item_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  vms_decide u_decide (
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= vms_pkg::STATE_RESET;
    end else begin
      item_valid_q <= in_accept || (item_valid_q && !fire);
      if (fire) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.command     <= command_i;
      item_q.now_ms      <= now_ms_i;
      item_q.fault_code  <= fault_code_i;
      item_q.vx          <= cmd_vx_i;
      item_q.vy          <= cmd_vy_i;
      item_q.yaw         <= cmd_yaw_i;
      item_q.test_len_ms <= test_len_ms_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign status_o        = res_q.status;
  assign expired_o       = res_q.expired;
  assign motion_mode_o   = res_q.snap.motion;
  assign session_mode_o  = res_q.snap.session;
  assign fault_out_o     = res_q.snap.fault;
  assign entered_at_ms_o = res_q.snap.entered_ms;
  assign deadline_out_o  = res_q.snap.deadline;
  assign held_vx_o       = res_q.snap.hold_vx;
  assign held_vy_o       = res_q.snap.hold_vy;
  assign held_yaw_o      = res_q.snap.hold_yaw;
  assign bridge_live_o   = res_q.bridge_live;

endmodule

@@ bench/vehicle_mode_supervisor_tb.sv @@
// Self-checking bench for vehicle_mode_supervisor: directed command sequences, then
// random mode traffic, mostly steered to legal commands, under three stall mixes. Every result item is checked.
// Depends on vms_pkg and the vehicle_mode_supervisor RTL.
`timescale 1ns / 1ps

module vehicle_mode_supervisor_tb;
  import vms_pkg::*;

  localparam logic [3:0] CMD_SPARE_A    = 4'd14;
  localparam logic [3:0] CMD_SPARE_B    = 4'd15;
  localparam logic [2:0] FAULT_CODE_OOR = 3'd7;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [3:0]         command_i     = '0;
  logic [31:0]        now_ms_i      = '0;
  logic [2:0]         fault_code_i  = '0;
  logic signed [15:0] cmd_vx_i      = '0;
  logic signed [15:0] cmd_vy_i      = '0;
  logic signed [31:0] cmd_yaw_i     = '0;
  logic [31:0]        test_len_ms_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               status_o;
  logic               expired_o;
  logic [2:0]         motion_mode_o;
  logic [1:0]         session_mode_o;
  logic [2:0]         fault_out_o;
  logic [31:0]        entered_at_ms_o;
  logic [31:0]        deadline_out_o;
  logic signed [15:0] held_vx_o;
  logic signed [15:0] held_vy_o;
  logic signed [31:0] held_yaw_o;
  logic               bridge_live_o;

  vehicle_mode_supervisor u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .now_ms_i       (now_ms_i),
    .fault_code_i   (fault_code_i),
    .cmd_vx_i       (cmd_vx_i),
    .cmd_vy_i       (cmd_vy_i),
    .cmd_yaw_i      (cmd_yaw_i),
    .test_len_ms_i  (test_len_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .expired_o      (expired_o),
    .motion_mode_o  (motion_mode_o),
    .session_mode_o (session_mode_o),
    .fault_out_o    (fault_out_o),
    .entered_at_ms_o(entered_at_ms_o),
    .deadline_out_o (deadline_out_o),
    .held_vx_o      (held_vx_o),
    .held_vy_o      (held_vy_o),
    .held_yaw_o     (held_yaw_o),
    .bridge_live_o  (bridge_live_o)
  );

  state_t      mirror = STATE_RESET;
  result_t     snapshot_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned directed_items = 0;
  int unsigned results_checked = 0;
  int unsigned expired_seen = 0;
  int unsigned rejected_seen = 0;
  int unsigned mismatches = 0;
  logic [31:0] clock_ms = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               snapshot_q.size());
      $display("vehicle_mode_supervisor_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void settle(motion_e m, session_e s, fault_e f, logic [31:0] t);
    mirror.motion     = m;
    mirror.session    = s;
    mirror.fault      = f;
    mirror.entered_ms = t;
  endfunction

  function automatic void drop_hold();
    mirror.deadline = '0;
    mirror.hold_vx  = '0;
    mirror.hold_vy  = '0;
    mirror.hold_yaw = '0;
  endfunction

  function automatic result_t supervise(input item_t it);
    result_t     r;
    logic [31:0] lag;
    fault_e      reason;
    r = '0;
    lag = it.now_ms - mirror.deadline;
    reason = (it.fault_code == FLT_NONE || it.fault_code > FLT_INVALID) ?
             FLT_INVALID : fault_e'(it.fault_code);
    case (it.command)
      CMD_REINIT: begin
        drop_hold();
        settle(MOT_BOOT, SES_VIEW, FLT_NONE, it.now_ms);
      end
      CMD_FINISH_BOOT: begin
        if (mirror.motion == MOT_BOOT) settle(MOT_IDLE, SES_VIEW, FLT_NONE, it.now_ms);
      end
      CMD_ENTER_REMOTE: begin
        if ((mirror.motion == MOT_IDLE || mirror.motion == MOT_REMOTE) &&
            (mirror.session == SES_VIEW || mirror.session == SES_REMOTE))
          settle(MOT_REMOTE, SES_REMOTE, FLT_NONE, it.now_ms);
        else
          r.status = 1'b1;
      end
      CMD_EXIT_REMOTE: begin
        // already out of remote in idle/view: accept without change
        if (mirror.motion == MOT_REMOTE && mirror.session == SES_REMOTE)
          settle(MOT_IDLE, SES_VIEW, FLT_NONE, it.now_ms);
        else if (!(mirror.motion == MOT_IDLE && mirror.session == SES_VIEW))
          r.status = 1'b1;
      end
      CMD_ENTER_TUNING: begin
        if (mirror.motion == MOT_IDLE || mirror.motion == MOT_TUNING) begin
          drop_hold();
          settle(MOT_TUNING, SES_TUNING, FLT_NONE, it.now_ms);
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_EXIT_TUNING: begin
        if (mirror.session == SES_TUNING) begin
          drop_hold();
          settle(MOT_IDLE, SES_VIEW, FLT_NONE, it.now_ms);
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_ARM_AUTO: begin
        if (mirror.motion == MOT_IDLE && mirror.session == SES_VIEW)
          settle(MOT_ARMED, SES_VIEW, FLT_NONE, it.now_ms);
        else
          r.status = 1'b1;
      end
      CMD_START_AUTO: begin
        if (mirror.motion == MOT_ARMED) settle(MOT_RUNNING, SES_VIEW, FLT_NONE, it.now_ms);
        else r.status = 1'b1;
      end
      CMD_STOP: begin
        drop_hold();
        settle(MOT_IDLE, SES_VIEW, FLT_NONE, it.now_ms);
      end
      CMD_CLEAR_FAULT: begin
        if (mirror.motion == MOT_FAULT) begin
          drop_hold();
          settle(MOT_IDLE, SES_VIEW, FLT_NONE, it.now_ms);
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_ENTER_FAULT: begin
        drop_hold();
        settle(MOT_FAULT, SES_VIEW, reason, it.now_ms);
      end
      CMD_START_MANUAL: begin
        if (mirror.motion == MOT_TUNING && mirror.session == SES_TUNING) begin
          mirror.hold_vx  = it.vx;
          mirror.hold_vy  = it.vy;
          mirror.hold_yaw = it.yaw;
          // an all-zero command keeps tuning and arms no deadline
          if (it.vx == 0 && it.vy == 0 && it.yaw == 0) begin
            mirror.deadline = '0;
            settle(MOT_TUNING, SES_TUNING, FLT_NONE, it.now_ms);
          end else begin
            mirror.deadline = it.now_ms + it.test_len_ms;
            settle(MOT_MANUAL, SES_TUNING, FLT_NONE, it.now_ms);
          end
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_CHECK_EXPIRY: begin
        // signed wrap compare; a zero deadline never expires
        if (mirror.motion == MOT_MANUAL && mirror.deadline != 0 && !lag[31]) begin
          drop_hold();
          settle(MOT_TUNING, SES_TUNING, FLT_NONE, it.now_ms);
          r.expired = 1'b1;
        end
      end
      default: ;
    endcase
    r.snap = mirror;
    r.bridge_live = (mirror.motion == MOT_REMOTE && mirror.session == SES_REMOTE);
    return r;
  endfunction

  // ---------------------------------------------------------------- result check

  function automatic string show(input result_t r);
    return $sformatf({"st=%0b exp=%0b mot=%0d ses=%0d flt=%0d ent=%h dl=%h",
                      " vx=%h vy=%h yaw=%h ra=%0b"},
                     r.status, r.expired, r.snap.motion, r.snap.session, r.snap.fault,
                     r.snap.entered_ms, r.snap.deadline, r.snap.hold_vx, r.snap.hold_vy,
                     r.snap.hold_yaw, r.bridge_live);
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status          = status_o;
      got.expired         = expired_o;
      got.snap.motion     = motion_e'(motion_mode_o);
      got.snap.session    = session_e'(session_mode_o);
      got.snap.fault      = fault_e'(fault_out_o);
      got.snap.entered_ms = entered_at_ms_o;
      got.snap.deadline   = deadline_out_o;
      got.snap.hold_vx    = held_vx_o;
      got.snap.hold_vy    = held_vy_o;
      got.snap.hold_yaw   = held_yaw_o;
      got.bridge_live     = bridge_live_o;
      if (snapshot_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result item: %s", show(got));
      end else begin
        want = snapshot_q.pop_front();
        results_checked++;
        if (want.expired) expired_seen++;
        if (want.status) rejected_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on result %0d", results_checked);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------- stimulus

  function automatic item_t cmd_item(logic [3:0] c, logic [31:0] t, logic [2:0] fc,
                                     logic signed [15:0] vx, logic signed [15:0] vy,
                                     logic signed [31:0] yaw, logic [31:0] dur);
    item_t it;
    it.command     = c;
    it.now_ms      = t;
    it.fault_code  = fc;
    it.vx          = vx;
    it.vy          = vy;
    it.yaw         = yaw;
    it.test_len_ms = dur;
    return it;
  endfunction

  // Hold the payload until the item is taken; an optional gap drops valid first.
  task automatic send_item(input item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    command_i     <= it.command;
    now_ms_i      <= it.now_ms;
    fault_code_i  <= it.fault_code;
    cmd_vx_i      <= it.vx;
    cmd_vy_i      <= it.vy;
    cmd_yaw_i     <= it.yaw;
    test_len_ms_i <= it.test_len_ms;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    snapshot_q.push_back(supervise(it));
    items_sent++;
  endtask

  function automatic logic [15:0] motion_part16();
    int unsigned roll;
    roll = $urandom_range(2);
    if (roll == 0) return '0;
    if (roll == 1) return 16'($urandom_range(0, 200)) - 16'd100;
    return 16'($urandom);
  endfunction

  // Steer the command by the current mode so most traffic walks legal paths.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 12);
    it.now_ms     = clock_ms;
    it.fault_code = 3'($urandom_range(7));
    if ($urandom_range(99) < 15) begin
      it.vx  = '0;
      it.vy  = '0;
      it.yaw = '0;
    end else begin
      it.vx  = motion_part16();
      it.vy  = motion_part16();
      it.yaw = ($urandom_range(2) == 0) ? 32'sd0 : $urandom;
    end
    roll = $urandom_range(99);
    if (roll < 5) it.test_len_ms = 32'd0 - it.now_ms;
    else if (roll < 15) it.test_len_ms = $urandom;
    else it.test_len_ms = $urandom_range(0, 40);
    pick = $urandom_range(99);
    if ($urandom_range(99) < 20) begin
      it.command = 4'($urandom_range(15));
    end else begin
      case (mirror.motion)
        MOT_BOOT:    it.command = pick < 85 ? CMD_FINISH_BOOT : CMD_READ;
        MOT_IDLE:    it.command = pick < 25 ? CMD_ENTER_REMOTE :
                                  pick < 55 ? CMD_ENTER_TUNING :
                                  pick < 75 ? CMD_ARM_AUTO :
                                  pick < 85 ? CMD_EXIT_REMOTE : CMD_ENTER_FAULT;
        MOT_REMOTE:  it.command = pick < 40 ? CMD_ENTER_REMOTE :
                                  pick < 70 ? CMD_EXIT_REMOTE :
                                  pick < 85 ? CMD_STOP : CMD_ENTER_TUNING;
        MOT_TUNING:  it.command = pick < 60 ? CMD_START_MANUAL :
                                  pick < 75 ? CMD_ENTER_TUNING :
                                  pick < 90 ? CMD_EXIT_TUNING : CMD_ARM_AUTO;
        MOT_MANUAL:  it.command = pick < 60 ? CMD_CHECK_EXPIRY :
                                  pick < 70 ? CMD_START_MANUAL :
                                  pick < 80 ? CMD_EXIT_TUNING :
                                  pick < 90 ? CMD_READ : CMD_STOP;
        MOT_ARMED:   it.command = pick < 60 ? CMD_START_AUTO :
                                  pick < 80 ? CMD_STOP : CMD_ENTER_REMOTE;
        MOT_RUNNING: it.command = pick < 50 ? CMD_STOP :
                                  pick < 75 ? CMD_ENTER_FAULT : CMD_START_AUTO;
        default:     it.command = pick < 60 ? CMD_CLEAR_FAULT :
                                  pick < 80 ? CMD_REINIT : CMD_ARM_AUTO;
      endcase
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_boot_and_reinit();
    send_item(cmd_item(CMD_READ, 32'd0, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_ENTER_REMOTE, 32'd1, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_FINISH_BOOT, 32'hFFFF_FFFF, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_FINISH_BOOT, 32'd5, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_SPARE_A, 32'd6, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_SPARE_B, 32'd7, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_REINIT, 32'd100, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_FINISH_BOOT, 32'd101, FLT_NONE, '0, '0, '0, '0));
  endtask

  task automatic test_remote_bridge();
    send_item(cmd_item(CMD_ENTER_REMOTE, 32'd200, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_ENTER_REMOTE, 32'd201, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_EXIT_REMOTE, 32'd202, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_EXIT_REMOTE, 32'd203, FLT_NONE, '0, '0, '0, '0));
  endtask

  task automatic test_tuning_and_manual();
    send_item(cmd_item(CMD_ENTER_TUNING, 32'd300, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_START_MANUAL, 32'd301, FLT_NONE, '0, '0, '0, 32'd50));
    send_item(cmd_item(CMD_START_MANUAL, 32'd302, FLT_NONE, 16'sh8000, 16'sh7FFF,
                       32'sh8000_0000, 32'd10));
    send_item(cmd_item(CMD_CHECK_EXPIRY, 32'd311, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_CHECK_EXPIRY, 32'd312, FLT_NONE, '0, '0, '0, '0));
    // deadline wraps to zero: the test never expires
    send_item(cmd_item(CMD_START_MANUAL, 32'hFFFF_FFF0, FLT_NONE, 16'sh0000, 16'sh0000,
                       32'sh7FFF_FFFF, 32'd16));
    send_item(cmd_item(CMD_CHECK_EXPIRY, 32'h0000_0010, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_EXIT_TUNING, 32'h0000_0011, FLT_NONE, '0, '0, '0, '0));
  endtask

  task automatic test_auto_and_faults();
    send_item(cmd_item(CMD_ARM_AUTO, 32'd400, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_START_AUTO, 32'd401, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_CLEAR_FAULT, 32'd402, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_ENTER_FAULT, 32'd403, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_CLEAR_FAULT, 32'd404, FLT_NONE, '0, '0, '0, '0));
    send_item(cmd_item(CMD_ENTER_FAULT, 32'd405, FAULT_CODE_OOR, '0, '0, '0, '0));
    send_item(cmd_item(CMD_STOP, 32'd406, FLT_NONE, '0, '0, '0, '0));
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned s_pct,
                                     input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_item(random_item());
  endtask

  initial begin
    send_idle_pct = 37;
    recv_idle_pct = 76;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boot_and_reinit();
    test_remote_bridge();
    test_tuning_and_manual();
    test_auto_and_faults();
    directed_items = items_sent;
    // start near the top of the time range so the clock wraps early
    clock_ms = 32'hFFFF_FE00;
    test_random_traffic(550, 37, 76);
    test_random_traffic(550, 76, 37);
    test_random_traffic(550, 0, 0);
    in_valid_i <= 1'b0;
    while (snapshot_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("covered %0d commands (%0d directed, rest random under three stall mixes)",
             items_sent, directed_items);
    $display("checked %0d results: %0d rejected commands, %0d manual tests expired, %0d bad",
             results_checked, rejected_seen, expired_seen, mismatches);
    if (mismatches == 0) begin
      $display("vehicle_mode_supervisor_tb OK");
    end else begin
      $display("vehicle_mode_supervisor_tb NOT OK");
    end
    $finish;
  end

endmodule
